[src/pwm_pattern_scorer_unit_defines.svh]
// Assertion macros for the position weight matrix scorer.
// Used by the top level; expects clk and arst_n in scope.
`ifndef PWM_PATTERN_SCORER_UNIT_DEFINES_SVH
`define PWM_PATTERN_SCORER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/pps_pkg.sv]
// Shared types, constants and functions of the weight matrix scorer.
// No dependencies; compiled first.
package pps_pkg;

	localparam int MAX_LEN  = 64;
	localparam int NBASE    = 4;
	localparam int CNT_W    = $clog2(MAX_LEN);
	localparam int LEN_W    = CNT_W + 1;
	localparam int BASE_W   = 2;
	localparam int W_W      = 16;
	localparam int SUM_W    = 24;
	localparam int ROW_W    = NBASE * W_W;
	localparam int CHAR_W   = 8;
	localparam int MODE_W   = 2;
	localparam int ML_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 7;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SCORE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

	// Result kinds
	localparam logic KIND_SCORE  = 1'b0;
	localparam logic KIND_BOUNDS = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MOTIF_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE   = 1'b1;

	// Control of one row flowing into the bounds unit
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} bnd_ctl_t;

	// Map an ASCII character to a base; hit is low for anything else
	function automatic logic [BASE_W:0] base_of(input logic [CHAR_W-1:0] ch);
		logic [BASE_W:0] r;
		case (ch)
			"A", "a": r = {1'b1, 2'd0};
			"C", "c": r = {1'b1, 2'd1};
			"G", "g": r = {1'b1, 2'd2};
			"T", "t": r = {1'b1, 2'd3};
			default:  r = {1'b0, 2'd0};
		endcase
		return r;
	endfunction

	// Saturating add of a weight into a 24-bit sum
	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [W_W-1:0] b
	);
		logic signed [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {{(SUM_W-W_W+1){b[W_W-1]}}, b};
		if (s[SUM_W] != s[SUM_W-1]) begin
			return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		return s[SUM_W-1:0];
	endfunction

endpackage

[src/pps_if.sv]
// Request and result channel interfaces of the weight matrix scorer.
// Depends on pps_pkg for field widths.
interface pps_in_if;
	import pps_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic [CNT_W-1:0]         position;
	logic [BASE_W-1:0]        base;
	logic signed [W_W-1:0]    weight;
	logic [CHAR_W-1:0]        character;

	modport source (output valid, mode, position, base, weight, character, input ready);
	modport sink (input valid, mode, position, base, weight, character, output ready);
endinterface

interface pps_out_if;
	import pps_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic signed [SUM_W-1:0]  score;
	logic signed [SUM_W-1:0]  max_score;
	logic signed [SUM_W-1:0]  min_score;

	modport source (output valid, kind, score, max_score, min_score, input ready);
	modport sink (input valid, kind, score, max_score, min_score, output ready);
endinterface

[src/pps_wmem.sv]
// Weight matrix memory: one row per motif position, four weight lanes.
// Lane write, registered read: the row appears in the cycle after its address. Uses pps_pkg.
module pps_wmem (
	input  logic                         clk,
	input  logic                         we,
	input  logic [pps_pkg::CNT_W-1:0]    waddr,
	input  logic [pps_pkg::BASE_W-1:0]   wlane,
	input  logic [pps_pkg::W_W-1:0]      wdata,
	input  logic [pps_pkg::CNT_W-1:0]    raddr,
	output logic [pps_pkg::ROW_W-1:0]    rdata
);
	import pps_pkg::*;

	logic [ROW_W-1:0] mem [MAX_LEN];

	// Write one lane of a row
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][wlane*W_W +: W_W] <= wdata;
		end
	end

	// Read a whole row
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

[src/pps_bounds.sv]
// Bounds unit: per-row maximum and minimum, then saturating accumulation.
// Fed rows from pps_wmem with bnd_ctl_t control; uses pps_pkg.
module pps_bounds (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pps_pkg::bnd_ctl_t                 ctl,
	input  logic [pps_pkg::ROW_W-1:0]         row,
	output logic                              done,
	output logic signed [pps_pkg::SUM_W-1:0]  hi,
	output logic signed [pps_pkg::SUM_W-1:0]  lo
);
	import pps_pkg::*;

	logic signed [W_W-1:0] mx, mn;
	logic signed [W_W-1:0] mx_s2, mn_s2;
	bnd_ctl_t              ctl_s2;
	logic signed [SUM_W-1:0] hi_q, lo_q;
	logic                  done_q;

	// Reduce the four lanes of a row
	always_comb begin
		logic signed [W_W-1:0] w;
		mx = row[W_W-1:0];
		mn = row[W_W-1:0];
		for (int b = 1; b < NBASE; b++) begin
			w = row[b*W_W +: W_W];
			if (w > mx) mx = w;
			if (w < mn) mn = w;
		end
	end

	// Register the reduced row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		mx_s2 <= mx;
		mn_s2 <= mn;
	end

	// Accumulate; restart on the first row, flag the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hi_q   <= '0;
			lo_q   <= '0;
		end else begin
			done_q <= ctl_s2.vld && ctl_s2.last;
			if (ctl_s2.vld) begin
				hi_q <= sat_add(ctl_s2.first ? '0 : hi_q, mx_s2);
				lo_q <= sat_add(ctl_s2.first ? '0 : lo_q, mn_s2);
			end
		end
	end

	assign done = done_q;
	assign hi   = hi_q;
	assign lo   = lo_q;
endmodule

[src/pwm_pattern_scorer_unit.sv]
// Position weight matrix scorer: write weight, score character, query bounds.
// A write takes effect on acceptance; a score character reads its row, then adds,
// and a pattern's score is valid in the cycle after the add of its last character.
// A bounds query reads one row a cycle, then a max/min stage and the accumulator.
// Reset clears the pattern count and sum and the registers (length 1,
// forward strand); the weight memory is not cleared. Uses pps_pkg, pps_if.
module pwm_pattern_scorer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pps_pkg::CFG_DAT_W-1:0]     cfg_data,
	pps_in_if.sink                            item,
	pps_out_if.source                         result
);
	import pps_pkg::*;
	`include "pwm_pattern_scorer_unit_defines.svh"

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ADD  = 4'b0010,
		ST_QRD  = 4'b0100,
		ST_QWT  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [ML_W-1:0]         motif_len_q;
	logic                    reverse_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        qpos_q;
	logic [LEN_W-1:0]        len;
	logic [CNT_W-1:0]        last_pos;
	logic [CNT_W-1:0]        cnt_eff;
	logic [CNT_W-1:0]        score_pos;
	logic [BASE_W:0]         hit_base;
	logic [BASE_W-1:0]       lane;
	logic                    pat_end;
	logic                    accept;
	logic                    lane_s1;
	logic [BASE_W-1:0]       lane_sel_s1;
	logic                    hit_s1;
	logic                    end_s1;
	logic [CNT_W-1:0]        raddr;
	logic [ROW_W-1:0]        rdata;
	bnd_ctl_t                bctl_s1;
	logic                    bdone;
	logic signed [SUM_W-1:0] bhi, blo;
	logic signed [SUM_W-1:0] new_sum;
	logic                    out_vld_q;
	logic                    out_kind_q;
	logic signed [SUM_W-1:0] out_score_q, out_max_q, out_min_q;

	// Effective motif length, clamped to one..MAX_LEN
	always_comb begin
		if (motif_len_q == '0) begin
			len = LEN_W'(1);
		end else if (LEN_W'(motif_len_q) > LEN_W'(MAX_LEN)) begin
			len = LEN_W'(MAX_LEN);
		end else begin
			len = LEN_W'(motif_len_q);
		end
	end
	assign last_pos = CNT_W'(len - LEN_W'(1));

	// Score address and base for the incoming character
	always_comb begin
		cnt_eff   = (LEN_W'(count_q) >= len) ? last_pos : count_q;
		hit_base  = base_of(item.character);
		score_pos = reverse_q ? (last_pos - cnt_eff) : cnt_eff;
		lane      = reverse_q ? (BASE_W'(NBASE - 1) - hit_base[BASE_W-1:0])
		                      : hit_base[BASE_W-1:0];
		pat_end   = (LEN_W'(cnt_eff) + LEN_W'(1)) >= len;
	end

	assign item.ready = (state_q == ST_IDLE) && (!out_vld_q || result.ready);
	assign accept     = item.valid && item.ready;
	assign raddr      = (state_q == ST_QRD) ? qpos_q : score_pos;

	pps_wmem u_wmem (
		.clk   (clk),
		.we    (accept && (item.mode == MODE_WRITE)),
		.waddr (item.position),
		.wlane (item.base),
		.wdata (item.weight),
		.raddr (raddr),
		.rdata (rdata)
	);

	pps_bounds u_bounds (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (bctl_s1),
		.row    (rdata),
		.done   (bdone),
		.hi     (bhi),
		.lo     (blo)
	);

	// Add the looked-up weight to the running sum
	assign new_sum = hit_s1 ? sat_add(sum_q, rdata[lane_sel_s1*W_W +: W_W]) : sum_q;

	// Sequencer, pattern count and sum, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			motif_len_q <= ML_W'(1);
			reverse_q   <= 1'b0;
			count_q     <= '0;
			sum_q       <= '0;
			qpos_q      <= '0;
			lane_s1     <= 1'b0;
			bctl_s1     <= '0;
		end else begin
			lane_s1 <= 1'b0;
			bctl_s1 <= '0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MOTIF_LEN: motif_len_q <= cfg_data[ML_W-1:0];
					REG_REVERSE:   reverse_q   <= cfg_data[0];
					default: ;
				endcase
				count_q <= '0;
				sum_q   <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (item.mode == MODE_SCORE)) begin
						lane_s1 <= 1'b1;
						count_q <= pat_end ? '0 : (cnt_eff + CNT_W'(1));
						state_q <= ST_ADD;
					end else if (accept && (item.mode == MODE_QUERY)) begin
						qpos_q  <= '0;
						state_q <= ST_QRD;
					end
				end
				ST_ADD: begin
					sum_q   <= end_s1 ? '0 : new_sum;
					state_q <= ST_IDLE;
				end
				ST_QRD: begin
					bctl_s1 <= '{vld: 1'b1, first: (qpos_q == '0), last: (qpos_q == last_pos)};
					qpos_q  <= qpos_q + CNT_W'(1);
					if (qpos_q == last_pos) begin
						state_q <= ST_QWT;
					end
				end
				ST_QWT: begin
					if (bdone) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the character decode alongside the memory read
	always_ff @(posedge clk) begin
		if (accept) begin
			lane_sel_s1 <= lane;
			hit_s1      <= hit_base[BASE_W];
			end_s1      <= pat_end;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			if (((state_q == ST_ADD) && end_s1) || ((state_q == ST_QWT) && bdone)) begin
				out_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_ADD) && end_s1) begin
			out_kind_q  <= KIND_SCORE;
			out_score_q <= new_sum;
			out_max_q   <= '0;
			out_min_q   <= '0;
		end else if ((state_q == ST_QWT) && bdone) begin
			out_kind_q  <= KIND_BOUNDS;
			out_score_q <= '0;
			out_max_q   <= bhi;
			out_min_q   <= blo;
		end
	end

	assign result.valid     = out_vld_q;
	assign result.kind      = out_kind_q;
	assign result.score     = out_score_q;
	assign result.max_score = out_max_q;
	assign result.min_score = out_min_q;

	`PPS_ASSERT_NEXT(a_score_to_add, accept && (item.mode == MODE_SCORE), state_q == ST_ADD, "score request did not enter add state")
	`PPS_ASSERT_NOW(a_done_in_wait, bdone, state_q == ST_QWT, "bounds done outside query wait")
	`PPS_ASSERT_NOW(a_count_in_range, 1'b1, LEN_W'(count_q) < len || cfg_we || $past(cfg_we), "pattern count beyond motif length")
	`PPS_ASSERT_NOW(a_lane_add, lane_s1, state_q == ST_ADD, "score lookup not followed by add")
endmodule
